// File: design/assert_macros.svh
// Assertion macros shared by the cipher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: design/xxt_pkg.sv
// Shared types, constants and helper functions for the XXTEA block cipher.
`default_nettype none

package xxt_pkg;

    // round constant
    localparam logic [31:0] DELTA = 32'h9e3779b9;

    // fixed part of the round count
    localparam logic [5:0] BASE_ROUNDS = 6'd6;

    // configuration register indexes
    localparam logic [2:0] REG_MODE        = 3'd0;
    localparam logic [2:0] REG_BLOCK_WORDS = 3'd1;
    localparam logic [2:0] REG_KEY_0       = 3'd2;
    localparam logic [2:0] REG_KEY_1       = 3'd3;
    localparam logic [2:0] REG_KEY_2       = 3'd4;
    localparam logic [2:0] REG_KEY_3       = 3'd5;

    // sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PREP,
        ST_PRIME1,
        ST_PRIME2,
        ST_RUN,
        ST_EMIT
    } state_t;

    // controls from the sequencer to the round datapath
    typedef struct packed {
        logic load_link;
        logic load_cur;
        logic step;
        logic decrypt;
    } round_ctrl_t;

    // rounds for a block of n words: 6 + 52/n, quotient by range
    function automatic logic [5:0] rounds_for(input logic [6:0] n);
        logic [5:0] q;
        if (n <= 7'd2)       q = 6'd26;
        else if (n == 7'd3)  q = 6'd17;
        else if (n == 7'd4)  q = 6'd13;
        else if (n == 7'd5)  q = 6'd10;
        else if (n == 7'd6)  q = 6'd8;
        else if (n == 7'd7)  q = 6'd7;
        else if (n == 7'd8)  q = 6'd6;
        else if (n <= 7'd10) q = 6'd5;
        else if (n <= 7'd13) q = 6'd4;
        else if (n <= 7'd17) q = 6'd3;
        else if (n <= 7'd26) q = 6'd2;
        else if (n <= 7'd52) q = 6'd1;
        else                 q = 6'd0;
        return BASE_ROUNDS + q;
    endfunction

endpackage

`default_nettype wire

// File: design/xxt_store.sv
// Word store: one write port, one registered read port, write-to-read forwarding.
`default_nettype none

module xxt_store #(
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [31:0]              wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [31:0]                   rd_data
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_q_reg;
    logic        fwd_hit_reg;
    logic [31:0] fwd_data_reg;

    // memory array, read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_q_reg <= mem[rd_addr];
    end

    // remember a write that collides with this cycle's read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= wr_data;
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_q_reg;

endmodule

`default_nettype wire

// File: design/xxt_round.sv
// Round datapath: carried operands and the XXTEA mix for one word update.
`default_nettype none

module xxt_round (
    input  wire logic                clk,
    input  wire xxt_pkg::round_ctrl_t ctrl,
    input  wire logic [31:0]         rd_data,
    input  wire logic [31:0]         round_sum,
    input  wire logic [1:0]          p_low,
    input  wire logic [3:0][31:0]    key,
    output logic [31:0]              new_word
);

    // link: z when encrypting, y when decrypting; cur: word being updated
    logic [31:0] link_reg;
    logic [31:0] cur_reg;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] k;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] mx;

    // operand routing and mix
    always_comb
    begin
        y  = ctrl.decrypt ? link_reg : rd_data;
        z  = ctrl.decrypt ? rd_data : link_reg;
        k  = key[p_low ^ round_sum[3:2]];
        a  = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
        b  = (round_sum ^ y) + (k ^ z);
        mx = a ^ b;
        new_word = ctrl.decrypt ? (cur_reg - mx) : (cur_reg + mx);
    end

    // neighbor read becomes the next word to update
    always_ff @(posedge clk)
    begin
        if (ctrl.load_link)
        begin
            link_reg <= rd_data;
        end
        if (ctrl.load_cur)
        begin
            cur_reg <= rd_data;
        end
        if (ctrl.step)
        begin
            link_reg <= new_word;
            cur_reg  <= rd_data;
        end
    end

endmodule

`default_nettype wire

// File: design/xxt_out_q.sv
// Two-entry output queue between the store read port and the result channel.
`default_nettype none

module xxt_out_q (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire logic [31:0] push_word,
    input  wire logic        push_last,
    input  wire logic        pop,
    output logic             valid,
    output logic [31:0]      word,
    output logic             last,
    output logic [1:0]       count
);

    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic [31:0] word0_reg;
    logic [31:0] word1_reg;
    logic        last0_reg;
    logic        last1_reg;

    assign count_next = count_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // entry 0 is the head
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            word0_reg <= word1_reg;
            last0_reg <= last1_reg;
        end
        if (push)
        begin
            if ((count_reg == 2'd0) || ((count_reg == 2'd1) && pop))
            begin
                word0_reg <= push_word;
                last0_reg <= push_last;
            end
            else
            begin
                word1_reg <= push_word;
                last1_reg <= push_last;
            end
        end
    end

    assign valid = (count_reg != 2'd0);
    assign word  = word0_reg;
    assign last  = last0_reg;
    assign count = count_reg;

endmodule

`default_nettype wire

// File: design/xxtea_block_cipher.sv
// Top level: XXTEA block cipher sequencer, configuration and channel wiring.
//
//  channel   signals                              direction  word
//  config    cfg_write_en cfg_index cfg_data      in         register write, no wait
//  input     in_valid in_ready data_word          in         one block word
//  output    out_valid out_ready result_word      out        one result word
//            last_word
//
// A block of n words loads at one word a cycle; after a prep step and two prime
// reads the transform runs rounds * n word updates (rounds = 6 + 52/n), one a cycle through
// the single store read port; then n results leave at up to one a cycle.
// A two-word block runs the most rounds (32).
// Input is taken only while loading; results queue in a two-entry buffer.
// A stalled output holds the emit phase until the queue has room; the last
// two words of a block may still wait there while the next block loads.
// Reset clears control state; the word store needs no clearing.
`default_nettype none
`include "assert_macros.svh"

module xxtea_block_cipher #(
    parameter int MAX_WORDS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] data_word,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      result_word,
    output logic             last_word
);

    localparam int AW = $clog2(MAX_WORDS);

    xxt_pkg::state_t      state_reg;
    xxt_pkg::state_t      state_next;
    xxt_pkg::round_ctrl_t rctl;

    logic             mode_reg;
    logic [6:0]       block_words_reg;
    logic [3:0][31:0] key_reg;

    logic [6:0]  load_count_reg;
    logic [6:0]  load_count_next;
    logic [6:0]  n_reg;
    logic [6:0]  n_next;
    logic [6:0]  p_reg;
    logic [6:0]  p_next;
    logic [6:0]  emit_idx_reg;
    logic [6:0]  emit_idx_next;
    logic [5:0]  rounds_left_reg;
    logic [5:0]  rounds_left_next;
    logic [31:0] round_sum_reg;
    logic [31:0] round_sum_next;
    logic        inflight_reg;
    logic        tag_last_reg;

    logic [6:0]  n_eff;
    logic [6:0]  n_last;
    logic [6:0]  load_count_inc;
    logic [6:0]  first_p;
    logic [6:0]  p_walk;
    logic        in_fire;
    logic        in_range;
    logic        load_done;
    logic        last_in_round;
    logic        issue;
    logic        out_pop;
    logic        space;
    logic [2:0]  occ;
    logic [1:0]  q_count;

    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [31:0]   mem_wr_data;
    logic [AW-1:0] mem_rd_addr;
    logic [31:0]   mem_rd_data;
    logic [31:0]   new_word;

    // neighbor word read ahead of the update of word q
    function automatic logic [6:0] nbr_index(input logic [6:0] q, input logic [6:0] n,
                                             input logic dec);
        logic [6:0] r;
        if (dec)
        begin
            r = (q == 7'd0) ? (n - 7'd1) : (q - 7'd1);
        end
        else
        begin
            r = (q == (n - 7'd1)) ? 7'd0 : (q + 7'd1);
        end
        return r;
    endfunction

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= 1'b0;
            block_words_reg <= 7'd4;
            key_reg         <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                xxt_pkg::REG_MODE:        mode_reg        <= cfg_data[0];
                xxt_pkg::REG_BLOCK_WORDS: block_words_reg <= cfg_data[6:0];
                xxt_pkg::REG_KEY_0:       key_reg[0]      <= cfg_data;
                xxt_pkg::REG_KEY_1:       key_reg[1]      <= cfg_data;
                xxt_pkg::REG_KEY_2:       key_reg[2]      <= cfg_data;
                xxt_pkg::REG_KEY_3:       key_reg[3]      <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // block size clamp and load bookkeeping
    always_comb
    begin
        if (block_words_reg < 7'd2)
        begin
            n_eff = 7'd2;
        end
        else if (32'(block_words_reg) > MAX_WORDS)
        begin
            n_eff = 7'(MAX_WORDS);
        end
        else
        begin
            n_eff = block_words_reg;
        end
    end

    assign in_fire        = in_valid && in_ready;
    assign load_count_inc = load_count_reg + 7'd1;
    assign load_done      = in_fire && (load_count_inc >= n_eff);
    assign in_range       = 32'(load_count_reg) < MAX_WORDS;

    // walk through the block: forward to encrypt, backward to decrypt
    assign n_last        = n_reg - 7'd1;
    assign first_p       = mode_reg ? n_last : 7'd0;
    assign last_in_round = mode_reg ? (p_reg == 7'd0) : (p_reg == n_last);
    assign p_walk        = last_in_round ? first_p
                         : (mode_reg ? (p_reg - 7'd1) : (p_reg + 7'd1));

    // room in the output queue for one more read
    assign out_pop = out_valid && out_ready;
    assign occ     = 3'(q_count) + 3'(inflight_reg) - 3'(out_pop);
    assign space   = occ < 3'd2;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            xxt_pkg::ST_LOAD:
            begin
                if (load_done)
                begin
                    state_next = xxt_pkg::ST_PREP;
                end
            end
            xxt_pkg::ST_PREP:   state_next = xxt_pkg::ST_PRIME1;
            xxt_pkg::ST_PRIME1: state_next = xxt_pkg::ST_PRIME2;
            xxt_pkg::ST_PRIME2: state_next = xxt_pkg::ST_RUN;
            xxt_pkg::ST_RUN:
            begin
                if (last_in_round && (rounds_left_reg == 6'd1))
                begin
                    state_next = xxt_pkg::ST_EMIT;
                end
            end
            xxt_pkg::ST_EMIT:
            begin
                if (space && (emit_idx_reg == n_last))
                begin
                    state_next = xxt_pkg::ST_LOAD;
                end
            end
            default:            state_next = xxt_pkg::ST_LOAD;
        endcase
    end

    // state outputs: handshake, store ports, datapath controls
    always_comb
    begin
        in_ready       = 1'b0;
        issue          = 1'b0;
        rctl.load_link = 1'b0;
        rctl.load_cur  = 1'b0;
        rctl.step      = 1'b0;
        rctl.decrypt   = mode_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = AW'(p_reg);
        mem_wr_data    = new_word;
        mem_rd_addr    = AW'(emit_idx_reg);
        unique case (state_reg)
            xxt_pkg::ST_LOAD:
            begin
                in_ready    = 1'b1;
                mem_wr_en   = in_fire && in_range;
                mem_wr_addr = AW'(load_count_reg);
                mem_wr_data = data_word;
            end
            xxt_pkg::ST_PREP:
            begin
                // carried operand: last word to encrypt, first to decrypt
                mem_rd_addr = AW'(mode_reg ? 7'd0 : n_last);
            end
            xxt_pkg::ST_PRIME1:
            begin
                rctl.load_link = 1'b1;
                mem_rd_addr    = AW'(first_p);
            end
            xxt_pkg::ST_PRIME2:
            begin
                rctl.load_cur = 1'b1;
                mem_rd_addr   = AW'(nbr_index(p_reg, n_reg, mode_reg));
            end
            xxt_pkg::ST_RUN:
            begin
                rctl.step   = 1'b1;
                mem_wr_en   = 1'b1;
                mem_rd_addr = AW'(nbr_index(p_walk, n_reg, mode_reg));
            end
            xxt_pkg::ST_EMIT:
            begin
                issue = space;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // counters and round state
    always_comb
    begin
        load_count_next  = load_count_reg;
        n_next           = load_done ? n_eff : n_reg;
        p_next           = p_reg;
        emit_idx_next    = emit_idx_reg;
        rounds_left_next = rounds_left_reg;
        round_sum_next   = round_sum_reg;
        if (in_fire)
        begin
            load_count_next = load_done ? 7'd0 : load_count_inc;
        end
        case (state_reg)
            xxt_pkg::ST_PREP:
            begin
                p_next           = first_p;
                emit_idx_next    = 7'd0;
                rounds_left_next = xxt_pkg::rounds_for(n_reg);
            end
            xxt_pkg::ST_PRIME1:
            begin
                round_sum_next = mode_reg ? 32'(32'(rounds_left_reg) * xxt_pkg::DELTA)
                                          : xxt_pkg::DELTA;
            end
            xxt_pkg::ST_RUN:
            begin
                p_next = p_walk;
                if (last_in_round)
                begin
                    rounds_left_next = rounds_left_reg - 6'd1;
                    round_sum_next   = mode_reg ? (round_sum_reg - xxt_pkg::DELTA)
                                                : (round_sum_reg + xxt_pkg::DELTA);
                end
            end
            xxt_pkg::ST_EMIT:
            begin
                if (issue)
                begin
                    emit_idx_next = emit_idx_reg + 7'd1;
                end
            end
            default:
            begin
                p_next = p_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= xxt_pkg::ST_LOAD;
            load_count_reg  <= 7'd0;
            n_reg           <= 7'd4;
            p_reg           <= 7'd0;
            emit_idx_reg    <= 7'd0;
            rounds_left_reg <= 6'd0;
            round_sum_reg   <= 32'd0;
            inflight_reg    <= 1'b0;
            tag_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            load_count_reg  <= load_count_next;
            n_reg           <= n_next;
            p_reg           <= p_next;
            emit_idx_reg    <= emit_idx_next;
            rounds_left_reg <= rounds_left_next;
            round_sum_reg   <= round_sum_next;
            inflight_reg    <= issue;
            tag_last_reg    <= issue && (emit_idx_reg == n_last);
        end
    end

    xxt_store #(
        .DEPTH (MAX_WORDS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    xxt_round u_round (
        .clk       (clk),
        .ctrl      (rctl),
        .rd_data   (mem_rd_data),
        .round_sum (round_sum_reg),
        .p_low     (p_reg[1:0]),
        .key       (key_reg),
        .new_word  (new_word)
    );

    xxt_out_q u_out_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (inflight_reg),
        .push_word (mem_rd_data),
        .push_last (tag_last_reg),
        .pop       (out_pop),
        .valid     (out_valid),
        .word      (result_word),
        .last      (last_word),
        .count     (q_count)
    );

    // checks
    `ASSERT_IMPLIES(a_q_room, inflight_reg, (q_count != 2'd2) || out_pop, "output queue overflow")
    `ASSERT_IMPLIES(a_run_rounds, state_reg == xxt_pkg::ST_RUN, rounds_left_reg != 6'd0, "update with no round left")
    `ASSERT_IMPLIES(a_run_index, state_reg == xxt_pkg::ST_RUN, p_reg < n_reg, "word index outside block")
    `ASSERT_NEXT(a_emit_end, (state_reg == xxt_pkg::ST_EMIT) && (state_next == xxt_pkg::ST_LOAD), inflight_reg && tag_last_reg, "block ended without last word")

endmodule

`default_nettype wire

// File: test/xxtea_block_cipher_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for xxtea_block_cipher: random blocks, sizes, keys and handshake stalls.
module xxtea_block_cipher_tb;

    localparam int STORE_DEPTH   = 64;
    // the longest transform is at 64 words; leave margin
    localparam int SETTLE_CYCLES = 420;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [31:0] data;
        logic        last;
    } result_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic [2:0]  cfg_index    = xxt_pkg::REG_MODE;
    logic [31:0] cfg_data     = '0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic [31:0] data_word    = '0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic [31:0] result_word;
    logic        last_word;

    // stall percentages per side
    int unsigned send_gap_pct   = 0;
    int unsigned recv_stall_pct = 0;

    logic [31:0] pending_words[$];
    result_t     due_words[$];
    int          fail_count  = 0;
    int          cycle_count = 0;

    // cipher model: settings and block store
    logic        set_decrypt = 1'b0;
    logic [6:0]  set_size    = 7'd4;
    logic [31:0] set_key[4]  = '{default: '0};
    logic [31:0] blk_words[STORE_DEPTH] = '{default: '0};
    logic [6:0]  blk_fill    = '0;

    xxtea_block_cipher #(
        .MAX_WORDS(STORE_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .data_word(data_word),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .result_word(result_word),
        .last_word(last_word)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // effective block length, clamped to 2..STORE_DEPTH
    function automatic int block_len();
        if (set_size < 7'd2)
            return 2;
        if (set_size > STORE_DEPTH)
            return STORE_DEPTH;
        return int'(set_size);
    endfunction

    function automatic logic [31:0] xx_mix(input logic [31:0] y, input logic [31:0] z,
                                           input logic [31:0] sum, input int p,
                                           input logic [1:0] e);
        logic [31:0] a;
        logic [31:0] b;
        logic [1:0]  k;
        k = p[1:0] ^ e;
        a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
        b = (sum ^ y) + (set_key[k] ^ z);
        return a ^ b;
    endfunction

    function automatic void encrypt_block(input int n);
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] sum;
        logic [1:0]  e;
        int          r;
        int          p;
        z   = blk_words[n - 1];
        sum = '0;
        for (r = 0; r < 6 + 52 / n; r++)
        begin
            sum = sum + xxt_pkg::DELTA;
            e   = sum[3:2];
            for (p = 0; p < n - 1; p++)
            begin
                y = blk_words[p + 1];
                blk_words[p] = blk_words[p] + xx_mix(y, z, sum, p, e);
                z = blk_words[p];
            end
            y = blk_words[0];
            blk_words[n - 1] = blk_words[n - 1] + xx_mix(y, z, sum, n - 1, e);
            z = blk_words[n - 1];
        end
    endfunction

    function automatic void decrypt_block(input int n);
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] sum;
        logic [1:0]  e;
        int          rounds;
        int          r;
        int          p;
        rounds = 6 + 52 / n;
        sum    = xxt_pkg::DELTA * 32'(rounds);
        y      = blk_words[0];
        for (r = 0; r < rounds; r++)
        begin
            e = sum[3:2];
            for (p = n - 1; p > 0; p--)
            begin
                z = blk_words[p - 1];
                blk_words[p] = blk_words[p] - xx_mix(y, z, sum, p, e);
                y = blk_words[p];
            end
            z = blk_words[n - 1];
            blk_words[0] = blk_words[0] - xx_mix(y, z, sum, 0, e);
            y   = blk_words[0];
            sum = sum - xxt_pkg::DELTA;
        end
    endfunction

    // store one accepted word; a full block queues its transformed words
    function automatic void absorb_word(input logic [31:0] w);
        int n;
        int i;
        n = block_len();
        if (blk_fill < STORE_DEPTH)
            blk_words[blk_fill] = w;
        blk_fill = blk_fill + 7'd1;
        if (blk_fill >= n)
        begin
            if (set_decrypt)
                decrypt_block(n);
            else
                encrypt_block(n);
            blk_fill = '0;
            for (i = 0; i < n; i++)
                due_words.push_back('{data: blk_words[i], last: (i == n - 1)});
        end
    endfunction

    function automatic void queue_random(input int count);
        int i;
        int pick;
        for (i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
                pending_words.push_back(32'h0000_0000);
            else if (pick == 1)
                pending_words.push_back(32'hffff_ffff);
            else
                pending_words.push_back($urandom);
        end
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            xxt_pkg::REG_MODE:        set_decrypt = val[0];
            xxt_pkg::REG_BLOCK_WORDS: set_size    = val[6:0];
            xxt_pkg::REG_KEY_0:       set_key[0]  = val;
            xxt_pkg::REG_KEY_1:       set_key[1]  = val;
            xxt_pkg::REG_KEY_2:       set_key[2]  = val;
            xxt_pkg::REG_KEY_3:       set_key[3]  = val;
            default: ;
        endcase
    endtask

    task automatic write_key(input logic [31:0] k0, input logic [31:0] k1,
                             input logic [31:0] k2, input logic [31:0] k3);
        write_reg(xxt_pkg::REG_KEY_0, k0);
        write_reg(xxt_pkg::REG_KEY_1, k1);
        write_reg(xxt_pkg::REG_KEY_2, k2);
        write_reg(xxt_pkg::REG_KEY_3, k3);
    endtask

    // nothing queued, in flight or owed, then let the datapath drain
    task automatic wait_idle();
        @(negedge clk);
        while (pending_words.size() != 0 || in_valid || due_words.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one random setting and a few blocks; sometimes a trailing partial block
    task automatic random_set(inout int sent);
        logic [6:0] size_reg;
        int         n;
        int         blocks;
        int         extra;
        int         pick;
        wait_idle();
        write_reg(xxt_pkg::REG_MODE, $urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 6)
            size_reg = 7'($urandom_range(0, 1));
        else if (pick < 18)
            size_reg = 7'($urandom_range(9, 16));
        else
            size_reg = 7'($urandom_range(2, 8));
        write_reg(xxt_pkg::REG_BLOCK_WORDS, {25'd0, size_reg});
        if ($urandom_range(0, 1))
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                write_key('0, '0, '0, '0);
            else if (pick == 1)
                write_key('1, '1, '1, '1);
            else
                write_key($urandom, $urandom, $urandom, $urandom);
        end
        n      = block_len();
        blocks = $urandom_range(1, 3);
        extra  = ($urandom_range(0, 99) < 15) ? $urandom_range(1, n - 1) : 0;
        queue_random(blocks * n + extra);
        sent += blocks * n + extra;
    endtask

    // driver: present pending words, feed the predictor on acceptance
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                absorb_word(data_word);
            if (!in_valid || in_ready)
            begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_gap_pct)
                begin
                    in_valid  <= 1'b1;
                    data_word <= pending_words.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: compare each accepted result word with the oldest one owed
    always @(posedge clk)
    begin
        result_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (due_words.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("unexpected result: word %h last %b", result_word, last_word);
                end
                else
                begin
                    want = due_words.pop_front();
                    if (result_word !== want.data || last_word !== want.last)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("mismatch: expected word %h last %b, got word %h last %b",
                                     want.data, want.last, result_word, last_word);
                    end
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int phase;
        int sent;
        int pick;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        send_gap_pct   = 12;
        recv_stall_pct = 62;

        // reset settings: encrypt, four words, zero key
        pending_words.push_back(32'h0000_0000);
        pending_words.push_back(32'hffff_ffff);
        pending_words.push_back(32'h0000_0000);
        pending_words.push_back(32'h0000_0001);

        // all-ones key, smallest block
        wait_idle();
        write_key('1, '1, '1, '1);
        write_reg(xxt_pkg::REG_BLOCK_WORDS, 32'd2);
        pending_words.push_back(32'hffff_ffff);
        pending_words.push_back(32'hffff_ffff);

        // decrypt, size below range acts as two
        wait_idle();
        write_reg(xxt_pkg::REG_MODE, 32'd1);
        write_reg(xxt_pkg::REG_BLOCK_WORDS, 32'd0);
        pending_words.push_back(32'h0000_0000);
        pending_words.push_back(32'h0000_0000);

        wait_idle();
        write_key(32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210);
        write_reg(xxt_pkg::REG_BLOCK_WORDS, 32'd1);
        pending_words.push_back(32'haaaa_aaaa);
        pending_words.push_back(32'h5555_5555);

        // size shrinks to the number of words already loaded
        wait_idle();
        write_reg(xxt_pkg::REG_MODE, 32'd0);
        write_reg(xxt_pkg::REG_BLOCK_WORDS, 32'd8);
        queue_random(3);
        wait_idle();
        write_reg(xxt_pkg::REG_BLOCK_WORDS, 32'd3);
        queue_random(1);

        wait_idle();
        write_reg(xxt_pkg::REG_MODE, 32'd1);
        queue_random(3);

        wait_idle();
        write_reg(xxt_pkg::REG_MODE, 32'd0);
        write_reg(xxt_pkg::REG_BLOCK_WORDS, 32'd5);
        queue_random(5);

        // random part over three stall profiles
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_gap_pct   = 12;
                    recv_stall_pct = 62;
                end
                1:
                begin
                    send_gap_pct   = 62;
                    recv_stall_pct = 12;
                end
                default:
                begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
            endcase
            // one block at the largest size, register at or above the limit
            if (phase == 1)
            begin
                wait_idle();
                write_reg(xxt_pkg::REG_MODE, $urandom_range(0, 1));
                pick = $urandom_range(0, 1);
                write_reg(xxt_pkg::REG_BLOCK_WORDS, pick ? 32'd64 : $urandom_range(65, 127));
                write_key($urandom, $urandom, $urandom, $urandom);
                queue_random(STORE_DEPTH);
            end
            sent = 0;
            while (sent < 8)
                random_set(sent);
        end

        wait_idle();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: xxtea_block_cipher.f
+incdir+design
design/xxt_pkg.sv
design/xxt_store.sv
design/xxt_round.sv
design/xxt_out_q.sv
design/xxtea_block_cipher.sv
test/xxtea_block_cipher_tb.sv
